>>> hdl/mbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_pkg - shared types and codes of the Modbus RTU master frame engine
// Command, kind and status codes, protocol constants and the CRC control
// word passed between the top level and the CRC engine.
// ----------------------------------------------------------------------------
package mbm_pkg;

	// buffer and word store sizing
	localparam int BUFFER_BYTES_DEFAULT = 64;
	localparam int MAX_WORDS            = 29;

	// input command codes (tuser of the slave side)
	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_BYTE    = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	// result kind codes (tuser of the master side)
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// transaction status codes
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_TIMEOUT   = 3'd1;
	localparam logic [2:0] STATUS_EXCEPTION = 3'd2;
	localparam logic [2:0] STATUS_BYTECOUNT = 3'd3;
	localparam logic [2:0] STATUS_CRC       = 3'd4;
	localparam logic [2:0] STATUS_BADCOUNT  = 3'd5;

	// protocol constants
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  EXCEPTION_MASK    = 8'h80;
	localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// control word of the CRC engine
	typedef struct packed {
		logic       clear;
		logic       feed;
		logic [7:0] data;
	} crc_ctrl_t;

endpackage

>>> hdl/mbm_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_crc16 - byte-wide CRC-16 engine
// Reflected polynomial, one byte folded in per cycle while feed is set, preset by clear.
// ----------------------------------------------------------------------------
module mbm_crc16 (
	input  logic               clk,
	input  logic               arst_n,
	input  mbm_pkg::crc_ctrl_t ctrl,
	output logic [15:0]        crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// fold one byte, LSB first
	always_comb begin
		crc_next = crc_q ^ {8'h00, ctrl.data};
		for (int k = 0; k < 8; k++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ mbm_pkg::CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	// hold, preset or advance the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mbm_pkg::CRC_INIT;
		end else if (ctrl.clear) begin
			crc_q <= mbm_pkg::CRC_INIT;
		end else if (ctrl.feed) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

>>> hdl/mbm_word_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_word_ram - register word store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mbm_word_ram #(
	parameter int DEPTH  = mbm_pkg::MAX_WORDS,
	parameter int ADDR_W = $clog2(mbm_pkg::MAX_WORDS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered in the cycle after an enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/modbus_rtu_master_frame_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine_top - Modbus RTU master frame engine
// Builds function 3 / function 6 requests with CRC-16, collects the read
// response into a word store, checks it and replays the words with a status.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tuser cmd; tdata addr,count,value,byte
//  m_axis    out  m_axis_tvalid/tready   tuser kind; tdata word,status; tlast
//  cfg       in   cfg_we                 cfg_wdata slave address
//
//  A request is accepted, decoded and sent as eight transmit bytes; a received
//  byte or a timeout is decoded, ending in a status word if it closes the
//  frame; a good closing byte replays the stored words, paced by the single
//  read port of the store. Output stalls hold the sequencer; a finished word
//  waits in the output register while the next input word is accepted. Reset
//  is immediate; the word store needs no clearing as words replay once received.
// ----------------------------------------------------------------------------
module modbus_rtu_master_frame_engine_top #(
	parameter int BUFFER_BYTES = mbm_pkg::BUFFER_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // reg_addr[15:0], reg_count[20:16],
	                                   // reg_value[36:21], rx_byte[44:37]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // data_word[15:0], status[18:16]
	output logic [1:0]  m_axis_tuser,  // kind[1:0]
	output logic        m_axis_tlast
);

	localparam int FIT_WORDS  = (BUFFER_BYTES - 5) / 2;
	localparam int WORD_DEPTH = (FIT_WORDS < mbm_pkg::MAX_WORDS) ? FIT_WORDS
	                                                             : mbm_pkg::MAX_WORDS;
	localparam int ADDR_W     = $clog2(WORD_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TX,
		ST_DUMP,
		ST_STATUS
	} state_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_READ,
		MODE_WRITE
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [7:0]        slave_q;
	logic [1:0]        cmd_q;
	logic [15:0]       addr_q;
	logic [4:0]        count_q;
	logic [15:0]       value_q;
	logic [7:0]        byte_q;
	logic [6:0]        idx_q;
	logic [4:0]        pend_q;
	logic              exc_q;
	logic [7:0]        bcf_q;
	logic [7:0]        crc_lo_q;
	logic [7:0]        whb_q;
	logic [7:0]        tx_func_q;
	logic [15:0]       tx_val_q;
	logic [2:0]        tx_idx_q;
	logic [ADDR_W-1:0] wd_idx_q;
	logic [2:0]        status_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [15:0] out_word_q;
	logic [2:0]  out_status_q;
	logic        out_last_q;

	logic               slot_free;
	logic               out_load;
	logic [6:0]         expected;
	logic               rx_last;
	logic               rx_crclo;
	logic [6:0]         word_off;
	logic [5:0]         word_sel;
	logic [2:0]         rx_status;
	logic               in_bad;
	logic               byte_rd;
	logic [5:0]         wd_next;
	logic               wd_more;
	logic [7:0]         tx_byte;
	logic [15:0]        crc_val;
	mbm_pkg::crc_ctrl_t crc_ctrl;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [15:0]        ram_rdata;

	// response framing, checks and request byte select
	always_comb begin
		slot_free = !out_valid_q || m_axis_tready;
		out_load  = slot_free && (state_q inside {ST_TX, ST_DUMP, ST_STATUS});
		expected  = 7'd5 + {1'b0, pend_q, 1'b0};
		rx_last   = (idx_q + 7'd1) == expected;
		rx_crclo  = (idx_q + 7'd2) == expected;
		word_off  = idx_q - 7'd3;
		word_sel  = word_off[6:1];
		in_bad    = (count_q == 5'd0) || ({1'b0, count_q} > 6'(WORD_DEPTH));
		byte_rd   = (state_q == ST_DECODE) && (cmd_q == mbm_pkg::CMD_BYTE)
		            && (mode_q == MODE_READ);
		wd_next   = 6'(wd_idx_q) + 6'd1;
		wd_more   = wd_next < {1'b0, pend_q};

		if (exc_q) begin
			rx_status = mbm_pkg::STATUS_EXCEPTION;
		end else if (bcf_q != {2'b00, pend_q, 1'b0}) begin
			rx_status = mbm_pkg::STATUS_BYTECOUNT;
		end else if ({byte_q, crc_lo_q} != crc_val) begin
			rx_status = mbm_pkg::STATUS_CRC;
		end else begin
			rx_status = mbm_pkg::STATUS_OK;
		end

		case (tx_idx_q)
			3'd0:    tx_byte = slave_q;
			3'd1:    tx_byte = tx_func_q;
			3'd2:    tx_byte = addr_q[15:8];
			3'd3:    tx_byte = addr_q[7:0];
			3'd4:    tx_byte = tx_val_q[15:8];
			3'd5:    tx_byte = tx_val_q[7:0];
			3'd6:    tx_byte = crc_val[7:0];
			default: tx_byte = crc_val[15:8];
		endcase
	end

	// CRC engine control: preset on a new request and after it, feed bytes
	always_comb begin
		crc_ctrl = '0;
		if (state_q == ST_DECODE && (cmd_q == mbm_pkg::CMD_READ ||
		                             cmd_q == mbm_pkg::CMD_WRITE)) begin
			crc_ctrl.clear = 1'b1;
		end else if (byte_rd && !rx_last && !rx_crclo) begin
			crc_ctrl.feed = 1'b1;
			crc_ctrl.data = byte_q;
		end else if (state_q == ST_TX && slot_free) begin
			if (tx_idx_q < 3'd6) begin
				crc_ctrl.feed = 1'b1;
				crc_ctrl.data = tx_byte;
			end else if (tx_idx_q == 3'd7) begin
				crc_ctrl.clear = 1'b1;
			end
		end
	end

	// word store access; writes happen only while decoding a data byte and
	// reads only on the closing byte or during replay, so they never meet
	always_comb begin
		ram_we    = byte_rd && !rx_last && !rx_crclo && (idx_q >= 7'd3) && word_off[0]
		            && (word_sel < 6'(WORD_DEPTH));
		ram_waddr = word_sel[ADDR_W-1:0];
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (byte_rd && rx_last && rx_status == mbm_pkg::STATUS_OK) begin
			ram_re = 1'b1;
		end else if (state_q == ST_DUMP && slot_free && wd_more) begin
			ram_re    = 1'b1;
			ram_raddr = wd_next[ADDR_W-1:0];
		end
	end

	mbm_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc_val)
	);

	mbm_word_ram #(
		.DEPTH  (WORD_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({whb_q, byte_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, frame state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_IDLE;
			slave_q      <= mbm_pkg::SLAVE_ADDR_RESET;
			cmd_q        <= mbm_pkg::CMD_READ;
			addr_q       <= '0;
			count_q      <= '0;
			value_q      <= '0;
			byte_q       <= '0;
			idx_q        <= '0;
			pend_q       <= '0;
			exc_q        <= 1'b0;
			bcf_q        <= '0;
			crc_lo_q     <= '0;
			whb_q        <= '0;
			tx_func_q    <= '0;
			tx_val_q     <= '0;
			tx_idx_q     <= '0;
			wd_idx_q     <= '0;
			status_q     <= mbm_pkg::STATUS_OK;
			out_valid_q  <= 1'b0;
			out_kind_q   <= mbm_pkg::KIND_TX;
			out_word_q   <= '0;
			out_status_q <= mbm_pkg::STATUS_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				slave_q <= cfg_wdata;
			end

			// drop the output word once taken, unless a new one loads
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q   <= s_axis_tuser;
						addr_q  <= s_axis_tdata[15:0];
						count_q <= s_axis_tdata[20:16];
						value_q <= s_axis_tdata[36:21];
						byte_q  <= s_axis_tdata[44:37];
						state_q <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					tx_idx_q <= '0;
					wd_idx_q <= '0;
					case (cmd_q)
						mbm_pkg::CMD_READ: begin
							if (in_bad) begin
								mode_q   <= MODE_IDLE;
								idx_q    <= '0;
								status_q <= mbm_pkg::STATUS_BADCOUNT;
								state_q  <= ST_STATUS;
							end else begin
								pend_q    <= count_q;
								mode_q    <= MODE_READ;
								idx_q     <= '0;
								exc_q     <= 1'b0;
								bcf_q     <= '0;
								crc_lo_q  <= '0;
								whb_q     <= '0;
								tx_func_q <= mbm_pkg::FUNC_READ_HOLDING;
								tx_val_q  <= {11'd0, count_q};
								state_q   <= ST_TX;
							end
						end
						mbm_pkg::CMD_WRITE: begin
							mode_q    <= MODE_WRITE;
							idx_q     <= '0;
							exc_q     <= 1'b0;
							bcf_q     <= '0;
							crc_lo_q  <= '0;
							whb_q     <= '0;
							tx_func_q <= mbm_pkg::FUNC_WRITE_SINGLE;
							tx_val_q  <= value_q;
							state_q   <= ST_TX;
						end
						mbm_pkg::CMD_BYTE: begin
							state_q <= ST_IDLE;
							if (mode_q == MODE_READ) begin
								if (rx_last) begin
									mode_q   <= MODE_IDLE;
									idx_q    <= '0;
									status_q <= rx_status;
									if (rx_status == mbm_pkg::STATUS_OK) begin
										state_q <= ST_DUMP;
									end else begin
										state_q <= ST_STATUS;
									end
								end else begin
									if (rx_crclo) begin
										crc_lo_q <= byte_q;
									end else if (idx_q == 7'd1) begin
										exc_q <= |(byte_q & mbm_pkg::EXCEPTION_MASK);
									end else if (idx_q == 7'd2) begin
										bcf_q <= byte_q;
									end else if (idx_q >= 7'd3 && !word_off[0]) begin
										whb_q <= byte_q;
									end
									idx_q <= idx_q + 7'd1;
								end
							end else if (mode_q == MODE_WRITE) begin
								// discard the echo
								if (idx_q + 7'd1 >= 7'd8) begin
									mode_q <= MODE_IDLE;
									idx_q  <= '0;
								end else begin
									idx_q <= idx_q + 7'd1;
								end
							end
						end
						default: begin
							// receive timeout
							if (mode_q == MODE_READ) begin
								status_q <= mbm_pkg::STATUS_TIMEOUT;
								state_q  <= ST_STATUS;
							end else begin
								state_q <= ST_IDLE;
							end
							mode_q <= MODE_IDLE;
							idx_q  <= '0;
						end
					endcase
				end

				ST_TX: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= mbm_pkg::KIND_TX;
						out_word_q   <= {8'h00, tx_byte};
						out_status_q <= mbm_pkg::STATUS_OK;
						out_last_q   <= (tx_idx_q == 3'd7);
						tx_idx_q     <= tx_idx_q + 3'd1;
						if (tx_idx_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end

				ST_DUMP: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= mbm_pkg::KIND_WORD;
						out_word_q   <= ram_rdata;
						out_status_q <= mbm_pkg::STATUS_OK;
						out_last_q   <= 1'b0;
						if (wd_more) begin
							wd_idx_q <= wd_next[ADDR_W-1:0];
						end else begin
							state_q <= ST_STATUS;
						end
					end
				end

				ST_STATUS: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= mbm_pkg::KIND_STATUS;
						out_word_q   <= '0;
						out_status_q <= status_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_status_q, out_word_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// an accepted word is decoded before the next one is taken
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while decoding");

	// the store is never written and read in the same cycle
	a_ram_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("word store write and read collide");

	// replay stays inside the received words
	a_dump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (6'(wd_idx_q) < {1'b0, pend_q}))
		else $error("replay index beyond word count");

	// a status word always closes the run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == mbm_pkg::KIND_STATUS) |-> m_axis_tlast)
		else $error("status word without last");
`endif

endmodule

>>> bench/modbus_rtu_master_frame_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine_top_tb - self-checking bench of the RTU master
// Drives read, write, received byte and timeout words into the engine and
// compares every transmit byte, register word and status word it returns
// against a cycle-free model of the frame engine kept inside the bench.
// Runs several slave addresses, random idling on both streams, one long
// output stall and a stretch with no idling at all.
// ----------------------------------------------------------------------------
module modbus_rtu_master_frame_engine_top_tb;

	localparam int BUF_BYTES      = mbm_pkg::BUFFER_BYTES_DEFAULT;
	localparam int IDLE_PCT       = 18;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 5000;

	// one word on the input stream
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [4:0]  count;
		logic [15:0] value;
		logic [7:0]  rxb;
	} mb_item_t;

	// one word on the result stream
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] word;
		logic [2:0]  status;
		logic        last;
	} mb_result_t;

	typedef enum logic [1:0] {ENG_IDLE, ENG_READ, ENG_WRITE} eng_mode_t;

	typedef enum {REPLY_GOOD, REPLY_EXC, REPLY_BCNT, REPLY_CRC, REPLY_SHORT, REPLY_CUT}
		reply_flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_valid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_ready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// engine model state
	logic [7:0]  slave_addr_model;
	eng_mode_t   eng_mode;
	logic [6:0]  eng_index;
	logic [4:0]  eng_pending;
	logic [15:0] eng_crc;
	logic        eng_exc;
	logic [7:0]  eng_bcount;
	logic [7:0]  eng_crc_lo;
	logic [7:0]  eng_whi;
	logic [15:0] eng_words [0:mbm_pkg::MAX_WORDS-1];

	mb_item_t    commands_to_send [$];
	mb_result_t  engine_outputs_due [$];
	mb_item_t    on_bus;
	mb_result_t  seen_result;
	mb_result_t  due_result;

	int items_queued = 0;
	int items_taken  = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit hold_armed   = 1'b0;
	bit steady       = 1'b0;

	modbus_rtu_master_frame_engine_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// CRC-16, reflected, one byte
	function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ mbm_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [15:0] word,
	                                    logic [2:0] status, logic last);
		mb_result_t r;
		r.kind   = kind;
		r.word   = word;
		r.status = status;
		r.last   = last;
		engine_outputs_due.push_back(r);
	endfunction

	// expected bytes of a function 3 or 6 request
	function automatic void push_request_bytes(logic [7:0] func, logic [15:0] a,
	                                           logic [15:0] v);
		logic [7:0]  req [0:7];
		logic [15:0] crc;
		req[0] = slave_addr_model;
		req[1] = func;
		req[2] = a[15:8];
		req[3] = a[7:0];
		req[4] = v[15:8];
		req[5] = v[7:0];
		crc = mbm_pkg::CRC_INIT;
		for (int i = 0; i < 6; i++)
			crc = crc16_feed(crc, req[i]);
		req[6] = crc[7:0];
		req[7] = crc[15:8];
		for (int i = 0; i < 8; i++)
			push_result(mbm_pkg::KIND_TX, {8'h00, req[i]}, mbm_pkg::STATUS_OK, i == 7);
	endfunction

	function automatic void open_reply(eng_mode_t m);
		eng_mode   = m;
		eng_index  = '0;
		eng_crc    = mbm_pkg::CRC_INIT;
		eng_exc    = 1'b0;
		eng_bcount = '0;
		eng_crc_lo = '0;
		eng_whi    = '0;
	endfunction

	// advance the engine model by one input word and queue what it emits
	function automatic void frame_engine_step(mb_item_t it);
		int         frame_len;
		int         idx;
		logic [2:0] st;
		case (it.cmd)
			mbm_pkg::CMD_READ: begin
				if (it.count == 0 || int'(it.count) > mbm_pkg::MAX_WORDS ||
				    5 + 2 * int'(it.count) > BUF_BYTES) begin
					eng_mode  = ENG_IDLE;
					eng_index = '0;
					push_result(mbm_pkg::KIND_STATUS, 16'h0000, mbm_pkg::STATUS_BADCOUNT,
					            1'b1);
				end else begin
					eng_pending = it.count;
					open_reply(ENG_READ);
					push_request_bytes(mbm_pkg::FUNC_READ_HOLDING, it.addr,
					                   {11'h000, it.count});
				end
			end
			mbm_pkg::CMD_WRITE: begin
				open_reply(ENG_WRITE);
				push_request_bytes(mbm_pkg::FUNC_WRITE_SINGLE, it.addr, it.value);
			end
			mbm_pkg::CMD_BYTE: begin
				if (eng_mode == ENG_READ) begin
					frame_len = 5 + 2 * int'(eng_pending);
					idx = int'(eng_index);
					if (idx + 1 == frame_len) begin
						// closing byte: exception, then byte count, then CRC
						if (eng_exc)
							st = mbm_pkg::STATUS_EXCEPTION;
						else if (eng_bcount != 8'(2 * int'(eng_pending)))
							st = mbm_pkg::STATUS_BYTECOUNT;
						else if ({it.rxb, eng_crc_lo} != eng_crc)
							st = mbm_pkg::STATUS_CRC;
						else
							st = mbm_pkg::STATUS_OK;
						eng_mode  = ENG_IDLE;
						eng_index = '0;
						if (st == mbm_pkg::STATUS_OK)
							for (int i = 0; i < int'(eng_pending); i++)
								push_result(mbm_pkg::KIND_WORD, eng_words[i],
								            mbm_pkg::STATUS_OK, 1'b0);
						push_result(mbm_pkg::KIND_STATUS, 16'h0000, st, 1'b1);
					end else begin
						if (idx + 2 == frame_len) begin
							eng_crc_lo = it.rxb;
						end else begin
							eng_crc = crc16_feed(eng_crc, it.rxb);
							if (idx == 1)
								eng_exc = (it.rxb & mbm_pkg::EXCEPTION_MASK) != 8'h00;
							else if (idx == 2)
								eng_bcount = it.rxb;
							else if (idx >= 3) begin
								if (((idx - 3) & 1) == 0)
									eng_whi = it.rxb;
								else
									eng_words[(idx - 3) >> 1] = {eng_whi, it.rxb};
							end
						end
						eng_index = 7'(idx + 1);
					end
				end else if (eng_mode == ENG_WRITE) begin
					// swallow the echo
					eng_index = eng_index + 7'd1;
					if (eng_index >= 7'd8) begin
						eng_mode  = ENG_IDLE;
						eng_index = '0;
					end
				end
			end
			default: begin
				if (eng_mode == ENG_READ)
					push_result(mbm_pkg::KIND_STATUS, 16'h0000, mbm_pkg::STATUS_TIMEOUT,
					            1'b1);
				eng_mode  = ENG_IDLE;
				eng_index = '0;
			end
		endcase
	endfunction

	// stimulus builders
	function automatic void queue_cmd(logic [1:0] cmd, logic [15:0] addr, logic [4:0] count,
	                                  logic [15:0] value, logic [7:0] rxb);
		mb_item_t it;
		it.cmd   = cmd;
		it.addr  = addr;
		it.count = count;
		it.value = value;
		it.rxb   = rxb;
		commands_to_send.push_back(it);
		items_queued++;
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		queue_cmd(mbm_pkg::CMD_BYTE, 16'($urandom), 5'($urandom), 16'($urandom), b);
	endfunction

	function automatic void queue_timeout();
		queue_cmd(mbm_pkg::CMD_TIMEOUT, 16'($urandom), 5'($urandom), 16'($urandom),
		          8'($urandom));
	endfunction

	function automatic void queue_read(logic [15:0] addr, logic [4:0] n);
		queue_cmd(mbm_pkg::CMD_READ, addr, n, 16'($urandom), 8'($urandom));
	endfunction

	// response frame for a read of n registers, damaged as flaw says
	function automatic void queue_read_reply(int n, reply_flaw_t flaw);
		logic [7:0]  frame [0:63];
		logic [15:0] crc;
		int          len;
		int          cut;
		len = 5 + 2 * n;
		frame[0] = 8'($urandom);
		frame[1] = ($urandom_range(4) == 0) ? 8'($urandom_range(127))
		                                    : mbm_pkg::FUNC_READ_HOLDING;
		frame[2] = 8'(2 * n);
		for (int k = 3; k < len - 2; k++)
			frame[k] = 8'($urandom);
		if (flaw == REPLY_EXC)
			frame[1] = frame[1] | mbm_pkg::EXCEPTION_MASK;
		if (flaw == REPLY_BCNT)
			frame[2] = frame[2] ^ (8'h01 << $urandom_range(7));
		crc = mbm_pkg::CRC_INIT;
		for (int k = 0; k < len - 2; k++)
			crc = crc16_feed(crc, frame[k]);
		frame[len - 2] = crc[7:0];
		frame[len - 1] = crc[15:8];
		if (flaw == REPLY_CRC) begin
			cut = len - 2 + int'($urandom_range(1));
			frame[cut] = frame[cut] ^ (8'h01 << $urandom_range(7));
		end
		cut = len;
		if (flaw == REPLY_SHORT || flaw == REPLY_CUT)
			cut = int'($urandom_range(len - 1));
		for (int k = 0; k < cut; k++)
			queue_byte(frame[k]);
		if (flaw == REPLY_SHORT)
			queue_timeout();
	endfunction

	function automatic void queue_random_transaction();
		int          pick;
		int          n;
		int          k;
		reply_flaw_t flaw;
		pick = int'($urandom_range(99));
		if (pick < 62) begin
			// read with mostly short frames
			k = int'($urandom_range(99));
			if (k < 70)
				n = int'($urandom_range(1, 4));
			else if (k < 90)
				n = int'($urandom_range(5, 15));
			else
				n = ($urandom_range(1) == 0) ? mbm_pkg::MAX_WORDS
				                             : int'($urandom_range(16, mbm_pkg::MAX_WORDS));
			queue_read(16'($urandom), 5'(n));
			k = int'($urandom_range(99));
			if (k < 55)      flaw = REPLY_GOOD;
			else if (k < 65) flaw = REPLY_EXC;
			else if (k < 75) flaw = REPLY_BCNT;
			else if (k < 85) flaw = REPLY_CRC;
			else if (k < 95) flaw = REPLY_SHORT;
			else             flaw = REPLY_CUT;
			queue_read_reply(n, flaw);
		end else if (pick < 78) begin
			// write with a full, short or overlong echo
			queue_cmd(mbm_pkg::CMD_WRITE, 16'($urandom), 5'($urandom), 16'($urandom),
			          8'($urandom));
			if ($urandom_range(99) < 20)
				k = int'($urandom_range(7));
			else
				k = ($urandom_range(3) == 0) ? int'($urandom_range(9, 10)) : 8;
			for (int i = 0; i < k; i++)
				queue_byte(8'($urandom));
			if (k < 8)
				queue_timeout();
		end else if (pick < 88) begin
			case ($urandom_range(2))
				0:       n = 0;
				1:       n = 30;
				default: n = 31;
			endcase
			queue_read(16'($urandom), 5'(n));
		end else begin
			k = int'($urandom_range(1, 3));
			for (int i = 0; i < k; i++)
				if ($urandom_range(1) == 0)
					queue_byte(8'($urandom));
				else
					queue_timeout();
		end
	endfunction

	function automatic void queue_random_phase(int budget);
		int start;
		start = items_queued;
		while (items_queued - start < budget)
			queue_random_transaction();
	endfunction

	task automatic drain_engine();
		while (items_taken != items_queued) @(posedge clk);
		while (engine_outputs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slave_address(logic [7:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		slave_addr_model = v;
	endtask

	// input driver: predict on every accepted word, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_valid && s_axis_tready) begin
				frame_engine_step(on_bus);
				items_taken++;
			end
			if (!s_valid || s_axis_tready) begin
				if (commands_to_send.size() != 0 &&
				    (steady || $urandom_range(99) >= IDLE_PCT)) begin
					on_bus = commands_to_send.pop_front();
					s_valid <= 1'b1;
					s_tdata <= {3'b000, on_bus.rxb, on_bus.value, on_bus.count, on_bus.addr};
					s_tuser <= on_bus.cmd;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: check against the oldest due word, pace tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_ready) begin
				seen_result.kind   = m_axis_tuser;
				seen_result.word   = m_axis_tdata[15:0];
				seen_result.status = m_axis_tdata[18:16];
				seen_result.last   = m_axis_tlast;
				if (engine_outputs_due.size() == 0) begin
					mismatches++;
					$display("%0t: expected none, actual kind=%0d data=%h status=%0d last=%b",
					         $time, seen_result.kind, seen_result.word,
					         seen_result.status, seen_result.last);
				end else begin
					due_result = engine_outputs_due.pop_front();
					if (seen_result.kind !== due_result.kind ||
					    seen_result.word !== due_result.word ||
					    seen_result.status !== due_result.status ||
					    seen_result.last !== due_result.last) begin
						mismatches++;
						$display({"%0t: mismatch expected kind=%0d data=%h status=%0d last=%b,",
						          " actual kind=%0d data=%h status=%0d last=%b"},
						         $time, due_result.kind, due_result.word,
						         due_result.status, due_result.last,
						         seen_result.kind, seen_result.word,
						         seen_result.status, seen_result.last);
					end
				end
			end
			// long hold-off once armed, so the engine backs up into its input
			if (hold_armed && m_axis_tvalid) begin
				hold_left  = HOLD_CYCLES;
				hold_armed = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_ready <= 1'b0;
			end else begin
				m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no word moving on either stream
	always @(posedge clk) begin
		if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		slave_addr_model = mbm_pkg::SLAVE_ADDR_RESET;
		eng_pending      = '0;
		open_reply(ENG_IDLE);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bad counts, idle drops, write and read timeouts, good read,
		// command while busy
		queue_read(16'h1234, 5'd0);
		queue_read(16'hFFFF, 5'd31);
		queue_read(16'h0000, 5'd30);
		queue_byte(8'hFF);
		queue_timeout();
		queue_cmd(mbm_pkg::CMD_WRITE, 16'hFFFF, 5'd0, 16'h0000, 8'h00);
		queue_timeout();
		queue_read(16'h0000, 5'd1);
		queue_read_reply(1, REPLY_GOOD);
		queue_read(16'hFFFF, 5'd1);
		queue_timeout();
		queue_read(16'h00FF, 5'd2);
		queue_cmd(mbm_pkg::CMD_WRITE, 16'h0000, 5'd31, 16'hFFFF, 8'hFF);
		queue_byte(8'h00);
		queue_timeout();
		queue_random_phase(70);
		drain_engine();

		write_slave_address(8'h00);
		queue_random_phase(85);
		drain_engine();

		// no idling on either side for this stretch
		write_slave_address(8'hFF);
		steady = 1'b1;
		queue_random_phase(85);
		drain_engine();
		steady = 1'b0;

		// receiver holds off while the sender keeps offering
		write_slave_address(8'($urandom_range(1, 254)));
		hold_armed = 1'b1;
		queue_random_phase(85);
		drain_engine();

		write_slave_address(8'($urandom));
		queue_random_phase(85);
		drain_engine();

		if (mismatches == 0 && engine_outputs_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/mbm_pkg.sv
hdl/mbm_crc16.sv
hdl/mbm_word_ram.sv
hdl/modbus_rtu_master_frame_engine_top.sv
bench/modbus_rtu_master_frame_engine_top_tb.sv
